[rtl/bis_pkg.sv]
// Shared types, codes and arithmetic for the bilinear image sampler.
// No dependencies; imported by every module of the block.
package bis_pkg;

  // Default image store geometry.
  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;

  // Item opcodes.
  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SAMPLE = 2'd1;
  localparam logic [1:0] OP_NORM   = 2'd2;
  localparam logic [1:0] OP_NONE   = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;

  localparam int CFG_W = 9;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RD0,
    ST_RD1,
    ST_RD2,
    ST_RD3,
    ST_BLY,
    ST_BLX
  } bis_state_t;

  // Controls from the sequencer to the blend datapath.
  typedef struct packed {
    logic       cap_en;
    logic [1:0] cap_idx;
    logic       y_en;
    logic       x_en;
  } bis_blend_ctl_t;

  // One channel blend: (a*(256-f) + b*f + 128) >> 8, rounded to nearest.
  function automatic logic [7:0] blend8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [7:0] f);
    logic [16:0] acc;
    acc = 17'(a) * 17'(9'd256 - 9'(f)) + 17'(b) * 17'(f) + 17'd128;
    return acc[15:8];
  endfunction

endpackage

[rtl/bis_store.sv]
// Single-port pixel store of 32-bit RGBA words with a registered read.
// Depends on bis_pkg for the default depth, MAX_WIDTH_DEF * MAX_HEIGHT_DEF.
module bis_store
  import bis_pkg::*;
#(
  parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [31:0]   wdata,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_r;

  // Write or read one word per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/bis_coord.sv]
// Coordinate unit: scales normalized positions, clamps to the image and
// splits into texel indexes and fractions. Depends on bis_pkg.
module bis_coord
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
  parameter int WW  = $clog2(MAX_WIDTH + 1),
  parameter int WH  = $clog2(MAX_HEIGHT + 1),
  parameter int PXW = (WW + 8 > 16) ? WW + 8 : 16,
  parameter int PYW = (WH + 8 > 16) ? WH + 8 : 16,
  parameter int XW  = PXW - 8,
  parameter int YW  = PYW - 8
) (
  input  logic          clk,
  input  logic          load,
  input  logic          setup,
  input  logic [1:0]    op,
  input  logic [15:0]   pos_x,
  input  logic [15:0]   pos_y,
  input  logic [WW-1:0] w,
  input  logic [WH-1:0] h,
  output logic [XW-1:0] x0,
  output logic [XW-1:0] x1,
  output logic [YW-1:0] y0,
  output logic [YW-1:0] y1,
  output logic [7:0]    fx,
  output logic [7:0]    fy
);

  logic [16+WW-1:0] prod_x;
  logic [16+WH-1:0] prod_y;
  logic [PXW-1:0]   px_nxt, px_r, hi_x, cx;
  logic [PYW-1:0]   py_nxt, py_r, hi_y, cy;
  logic [XW-1:0]    x0_r, x1_r;
  logic [YW-1:0]    y0_r, y1_r;
  logic [7:0]       fx_r, fy_r;

  // Normalized coordinates scale by the image size with rounding.
  always_comb begin
    prod_x = (16+WW)'(pos_x) * (16+WW)'(w) + (16+WW)'(128);
    prod_y = (16+WH)'(pos_y) * (16+WH)'(h) + (16+WH)'(128);
    if (op == OP_NORM) begin
      px_nxt = PXW'(prod_x[16+WW-1:8]);
      py_nxt = PYW'(prod_y[16+WH-1:8]);
    end else begin
      px_nxt = PXW'(pos_x);
      py_nxt = PYW'(pos_y);
    end
  end

  // Clamp below to 3/256 first, then above to size minus one.
  always_comb begin
    hi_x = PXW'({WW'(w - WW'(1)), 8'h00});
    hi_y = PYW'({WH'(h - WH'(1)), 8'h00});
    cx = (px_r < PXW'(3)) ? PXW'(3) : px_r;
    cy = (py_r < PYW'(3)) ? PYW'(3) : py_r;
    if (cx > hi_x) begin
      cx = hi_x;
    end
    if (cy > hi_y) begin
      cy = hi_y;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
    if (setup) begin
      fx_r <= cx[7:0];
      fy_r <= cy[7:0];
      x0_r <= cx[PXW-1:8];
      y0_r <= cy[PYW-1:8];
      x1_r <= cx[PXW-1:8] + XW'(cx[7:0] != 8'h00);
      y1_r <= cy[PYW-1:8] + YW'(cy[7:0] != 8'h00);
    end
  end

  assign x0 = x0_r;
  assign x1 = x1_r;
  assign y0 = y0_r;
  assign y1 = y1_r;
  assign fx = fx_r;
  assign fy = fy_r;

endmodule

[rtl/bis_blend.sv]
// Blend datapath: collects four texels, blends along y, then along x,
// and holds the result item. Depends on bis_pkg for blend8 and controls.
module bis_blend
  import bis_pkg::*;
(
  input  logic           clk,
  input  bis_blend_ctl_t ctl,
  input  logic [31:0]    rdata,
  input  logic [7:0]     fx,
  input  logic [7:0]     fy,
  output logic [31:0]    result
);

  logic [31:0] t00_r, t01_r, t10_r;
  logic [31:0] left_nxt, right_nxt, left_r, right_r;
  logic [31:0] res_nxt, res_r;

  // The fourth texel is used straight from the store output.
  always_comb begin
    for (int c = 0; c < 4; c++) begin
      left_nxt[8*c +: 8]  = blend8(t00_r[8*c +: 8], t01_r[8*c +: 8], fy);
      right_nxt[8*c +: 8] = blend8(t10_r[8*c +: 8], rdata[8*c +: 8], fy);
      res_nxt[8*c +: 8]   = blend8(left_r[8*c +: 8], right_r[8*c +: 8], fx);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.cap_en) begin
      case (ctl.cap_idx)
        2'd0:    t00_r <= rdata;
        2'd1:    t01_r <= rdata;
        default: t10_r <= rdata;
      endcase
    end
    if (ctl.y_en) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
    if (ctl.x_en) begin
      res_r <= res_nxt;
    end
  end

  assign result = res_r;

endmodule

[rtl/bilinear_image_sampler.sv]
// Bilinear image sampler top level: sequencer, configuration and handshakes.
// A write item leaves the sequencer idle. A sample item runs through setup, the
// four reads of the single-port store and two blend stages, holds in the x blend
// while the result is stalled, and blocks new items. Synchronous active-low reset
// clears control and sets both sizes to 256; the store is not cleared.
module bilinear_image_sampler
  import bis_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_op,
  input  logic [15:0]      in_pos_x,
  input  logic [15:0]      in_pos_y,
  input  logic [7:0]       in_red,
  input  logic [7:0]       in_green,
  input  logic [7:0]       in_blue,
  input  logic [7:0]       in_alpha,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [7:0]       out_red,
  output logic [7:0]       out_green,
  output logic [7:0]       out_blue,
  output logic [7:0]       out_alpha,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int WH    = $clog2(MAX_HEIGHT + 1);
  localparam int PXW   = (WW + 8 > 16) ? WW + 8 : 16;
  localparam int PYW   = (WH + 8 > 16) ? WH + 8 : 16;
  localparam int XW    = PXW - 8;
  localparam int YW    = PYW - 8;

  bis_state_t       state_r, state_nxt;
  logic [CFG_W-1:0] cfg_width_r, cfg_height_r;
  logic             out_valid_r, out_valid_nxt;
  logic [WW-1:0]    w;
  logic [WH-1:0]    h;
  logic             in_acc, is_sample, out_free;
  logic             wr_ok, mem_we, mem_re;
  logic [AW-1:0]    mem_addr, wr_addr, rd_addr;
  logic [XW-1:0]    x0, x1, rd_x;
  logic [YW-1:0]    y0, y1, rd_y;
  logic [7:0]       fx, fy;
  logic [31:0]      rdata, result;
  bis_blend_ctl_t   ctl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= CFG_W'(256);
      cfg_height_r <= CFG_W'(256);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WIDTH:  cfg_width_r  <= cfg_wdata;
        REG_HEIGHT: cfg_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sizes in use, saturated to one and to the store geometry.
  always_comb begin
    if (cfg_width_r == '0) begin
      w = WW'(1);
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(cfg_width_r);
    end
    if (cfg_height_r == '0) begin
      h = WH'(1);
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h = WH'(MAX_HEIGHT);
    end else begin
      h = WH'(cfg_height_r);
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign is_sample = (in_op == OP_SAMPLE) || (in_op == OP_NORM);
  assign out_free  = !out_valid_r || !out_stall;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_acc && is_sample) state_nxt = ST_SETUP;
      ST_SETUP: state_nxt = ST_RD0;
      ST_RD0:   state_nxt = ST_RD1;
      ST_RD1:   state_nxt = ST_RD2;
      ST_RD2:   state_nxt = ST_RD3;
      ST_RD3:   state_nxt = ST_BLY;
      ST_BLY:   state_nxt = ST_BLX;
      ST_BLX:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs: read coordinates and blend controls.
  always_comb begin
    mem_re      = 1'b0;
    rd_x        = x0;
    rd_y        = y0;
    ctl         = '0;
    unique case (state_r)
      ST_RD0: begin
        mem_re = 1'b1;
      end
      ST_RD1: begin
        mem_re      = 1'b1;
        rd_y        = y1;
        ctl.cap_en  = 1'b1;
        ctl.cap_idx = 2'd0;
      end
      ST_RD2: begin
        mem_re      = 1'b1;
        rd_x        = x1;
        ctl.cap_en  = 1'b1;
        ctl.cap_idx = 2'd1;
      end
      ST_RD3: begin
        mem_re      = 1'b1;
        rd_x        = x1;
        rd_y        = y1;
        ctl.cap_en  = 1'b1;
        ctl.cap_idx = 2'd2;
      end
      ST_BLY: begin
        ctl.y_en = 1'b1;
      end
      ST_BLX: begin
        ctl.x_en = out_free;
      end
      default: ;
    endcase
  end

  // Result handshake.
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == ST_BLX && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Store addressing; pixel writes use the port only while idle.
  always_comb begin
    wr_ok   = (32'(in_pos_x[15:8]) < 32'(w)) && (32'(in_pos_y[15:8]) < 32'(h));
    mem_we  = in_acc && (in_op == OP_WRITE) && wr_ok;
    wr_addr = AW'(in_pos_y[15:8]) * AW'(MAX_WIDTH) + AW'(in_pos_x[15:8]);
    rd_addr = AW'(rd_y) * AW'(MAX_WIDTH) + AW'(rd_x);
    mem_addr = (state_r == ST_IDLE) ? wr_addr : rd_addr;
  end

  bis_store #(
    .DEPTH(DEPTH),
    .AW   (AW)
  ) u_store (
    .clk  (clk),
    .we   (mem_we),
    .re   (mem_re),
    .addr (mem_addr),
    .wdata({in_alpha, in_blue, in_green, in_red}),
    .rdata(rdata)
  );

  bis_coord #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .WW        (WW),
    .WH        (WH),
    .PXW       (PXW),
    .PYW       (PYW),
    .XW        (XW),
    .YW        (YW)
  ) u_coord (
    .clk  (clk),
    .load (in_acc),
    .setup(state_r == ST_SETUP),
    .op   (in_op),
    .pos_x(in_pos_x),
    .pos_y(in_pos_y),
    .w    (w),
    .h    (h),
    .x0   (x0),
    .x1   (x1),
    .y0   (y0),
    .y1   (y1),
    .fx   (fx),
    .fy   (fy)
  );

  bis_blend u_blend (
    .clk   (clk),
    .ctl   (ctl),
    .rdata (rdata),
    .fx    (fx),
    .fy    (fy),
    .result(result)
  );

  assign out_valid = out_valid_r;
  assign out_red   = result[7:0];
  assign out_green = result[15:8];
  assign out_blue  = result[23:16];
  assign out_alpha = result[31:24];

`ifndef ASSERT_OFF
  // Pixel writes never collide with the read sequence.
  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_IDLE))
    else $error("store written outside idle");

  // An accepted sample item starts the setup step.
  a_sample_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && is_sample) |=> (state_r == ST_SETUP))
    else $error("sample item did not start");

  // A waiting result is never overwritten by the next blend.
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BLX && out_valid_r && out_stall) |=> (state_r == ST_BLX))
    else $error("result overwritten while stalled");

  // The last read is always followed by the y blend.
  a_read_to_blend: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD3) |=> (state_r == ST_BLY))
    else $error("read sequence broken");
`endif

endmodule

[sim/tb.sv]
// Self-checking testbench for the bilinear image sampler.
// Depends on rtl/bis_pkg.sv and rtl/bilinear_image_sampler.sv; predicts every
// sample with its own image copy and checks results in order.
`timescale 1ns / 1ps

module tb;
  import bis_pkg::*;

  // Indexes beyond the two real registers; writes to them must be ignored.
  localparam logic [1:0] REG_SPARE_A = 2'd2;
  localparam logic [1:0] REG_SPARE_B = 2'd3;

  localparam int STORE_WORDS = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int DRAIN_CYCLES = 16;
  localparam int LONG_HOLD_CYCLES = 300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    rgba_t       color;
  } pixel_item_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_op = OP_NONE;
  logic [15:0]      in_pos_x = '0;
  logic [15:0]      in_pos_y = '0;
  logic [7:0]       in_red = '0;
  logic [7:0]       in_green = '0;
  logic [7:0]       in_blue = '0;
  logic [7:0]       in_alpha = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [7:0]       out_red;
  logic [7:0]       out_green;
  logic [7:0]       out_blue;
  logic [7:0]       out_alpha;
  logic             cfg_we = 1'b0;
  logic [1:0]       cfg_index = REG_WIDTH;
  logic [CFG_W-1:0] cfg_wdata = '0;

  // Predicted image contents and the generator's record of written texels.
  rgba_t            image_mem [STORE_WORDS];
  bit               written_map [STORE_WORDS];
  logic [CFG_W-1:0] width_reg = 9'd256;
  logic [CFG_W-1:0] height_reg = 9'd256;

  pixel_item_t pending_items [$];
  rgba_t       expected_pixels [$];
  pixel_item_t on_bus;
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatch_count = 0;
  int          src_gap = 0;
  int          sink_gap = 0;
  int          hold_left = 0;
  bit          hold_req = 1'b0;
  bit          hold_done = 1'b0;
  bit          calm = 1'b0;

  bilinear_image_sampler uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_op    (in_op),
    .in_pos_x (in_pos_x),
    .in_pos_y (in_pos_y),
    .in_red   (in_red),
    .in_green (in_green),
    .in_blue  (in_blue),
    .in_alpha (in_alpha),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_red  (out_red),
    .out_green(out_green),
    .out_blue (out_blue),
    .out_alpha(out_alpha),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 0;
  end

  // A register value of zero acts as one; values above the store size saturate.
  function automatic int unsigned size_used(logic [CFG_W-1:0] r, int unsigned limit);
    if (r == 0) return 1;
    if (r > limit) return limit;
    return r;
  endfunction

  function automatic int unsigned pin_axis(int unsigned p, int unsigned size);
    int unsigned top;
    int unsigned v;
    top = (size - 1) * 256;
    v = p;
    if (v < 3) v = 3;
    if (v > top) v = top;
    return v;
  endfunction

  // Finds the four texels and the fractions that a sample item uses.
  function automatic void sample_corners(input logic [1:0] op, input logic [15:0] px,
                                         input logic [15:0] py,
                                         output int unsigned x0, output int unsigned y0,
                                         output int unsigned x1, output int unsigned y1,
                                         output logic [7:0] fx, output logic [7:0] fy);
    int unsigned w, h, sx, sy, cx, cy;
    w = size_used(width_reg, MAX_WIDTH_DEF);
    h = size_used(height_reg, MAX_HEIGHT_DEF);
    sx = px;
    sy = py;
    if (op == OP_NORM) begin
      sx = (sx * w + 128) >> 8;
      sy = (sy * h + 128) >> 8;
    end
    cx = pin_axis(sx, w);
    cy = pin_axis(sy, h);
    fx = cx[7:0];
    fy = cy[7:0];
    x0 = cx >> 8;
    y0 = cy >> 8;
    x1 = x0 + ((fx != 0) ? 1 : 0);
    y1 = y0 + ((fy != 0) ? 1 : 0);
  endfunction

  function automatic logic [7:0] mix8(logic [7:0] a, logic [7:0] b, logic [7:0] f);
    int unsigned ua, ub, uf, acc;
    ua = a;
    ub = b;
    uf = f;
    acc = ua * (256 - uf) + ub * uf + 128;
    return acc[15:8];
  endfunction

  // Blends along y first, then along x, channel by channel.
  function automatic rgba_t bilerp(rgba_t t00, rgba_t t01, rgba_t t10, rgba_t t11,
                                   logic [7:0] fx, logic [7:0] fy);
    rgba_t r;
    r.red   = mix8(mix8(t00.red, t01.red, fy), mix8(t10.red, t11.red, fy), fx);
    r.green = mix8(mix8(t00.green, t01.green, fy), mix8(t10.green, t11.green, fy), fx);
    r.blue  = mix8(mix8(t00.blue, t01.blue, fy), mix8(t10.blue, t11.blue, fy), fx);
    r.alpha = mix8(mix8(t00.alpha, t01.alpha, fy), mix8(t10.alpha, t11.alpha, fy), fx);
    return r;
  endfunction

  // Applies one accepted item to the predicted image and queues its result.
  function automatic void predict_pixel(pixel_item_t it);
    int unsigned x0, y0, x1, y1, w, h;
    logic [7:0] fx, fy;
    w = size_used(width_reg, MAX_WIDTH_DEF);
    h = size_used(height_reg, MAX_HEIGHT_DEF);
    case (it.op) inside
      OP_WRITE: begin
        x0 = it.pos_x[15:8];
        y0 = it.pos_y[15:8];
        if (x0 < w && y0 < h) image_mem[y0 * MAX_WIDTH_DEF + x0] = it.color;
      end
      OP_SAMPLE, OP_NORM: begin
        sample_corners(it.op, it.pos_x, it.pos_y, x0, y0, x1, y1, fx, fy);
        expected_pixels.push_back(bilerp(image_mem[y0 * MAX_WIDTH_DEF + x0],
                                         image_mem[y1 * MAX_WIDTH_DEF + x0],
                                         image_mem[y0 * MAX_WIDTH_DEF + x1],
                                         image_mem[y1 * MAX_WIDTH_DEF + x1], fx, fy));
      end
      default: begin
      end
    endcase
  endfunction

  function automatic rgba_t rand_color();
    return rgba_t'($urandom);
  endfunction

  task automatic queue_item(logic [1:0] op, logic [15:0] px, logic [15:0] py, rgba_t c);
    pixel_item_t it;
    it.op = op;
    it.pos_x = px;
    it.pos_y = py;
    it.color = c;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Writes a pixel at integer position (x, y); the fraction bits are noise.
  task automatic queue_write(int unsigned x, int unsigned y, rgba_t c);
    if (x < size_used(width_reg, MAX_WIDTH_DEF) && y < size_used(height_reg, MAX_HEIGHT_DEF))
      written_map[y * MAX_WIDTH_DEF + x] = 1'b1;
    queue_item(OP_WRITE, {x[7:0], 8'($urandom)}, {y[7:0], 8'($urandom)}, c);
  endtask

  // A sample is preceded by writes of any of its texels not yet written.
  task automatic queue_sample(logic [1:0] op, logic [15:0] px, logic [15:0] py);
    int unsigned x0, y0, x1, y1;
    logic [7:0] fx, fy;
    sample_corners(op, px, py, x0, y0, x1, y1, fx, fy);
    if (!written_map[y0 * MAX_WIDTH_DEF + x0]) queue_write(x0, y0, rand_color());
    if (!written_map[y1 * MAX_WIDTH_DEF + x0]) queue_write(x0, y1, rand_color());
    if (!written_map[y0 * MAX_WIDTH_DEF + x1]) queue_write(x1, y0, rand_color());
    if (!written_map[y1 * MAX_WIDTH_DEF + x1]) queue_write(x1, y1, rand_color());
    queue_item(op, px, py, '0);
  endtask

  // Register writes are made only while the block is idle.
  task automatic write_reg(logic [1:0] idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_WIDTH) width_reg = val;
    else if (idx == REG_HEIGHT) height_reg = val;
  endtask

  task automatic configure(logic [CFG_W-1:0] w, logic [CFG_W-1:0] h, logic [1:0] spare);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(spare, CFG_W'($urandom));
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_drained();
    while (items_taken != items_queued) @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Random mix: mostly samples, some overwrites, some ignored items.
  task automatic queue_random(int n);
    int unsigned w, h, pick, x, y;
    logic [15:0] px, py;
    w = size_used(width_reg, MAX_WIDTH_DEF);
    h = size_used(height_reg, MAX_HEIGHT_DEF);
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 7) == 0) begin
          px = 16'($urandom);
          py = 16'($urandom);
        end else begin
          px = 16'($urandom_range(0, w * 256 - 1));
          py = 16'($urandom_range(0, h * 256 - 1));
          if ($urandom_range(0, 5) == 0) px[7:0] = 8'h00;
          if ($urandom_range(0, 5) == 0) py[7:0] = 8'h00;
        end
        queue_sample(OP_SAMPLE, px, py);
      end else if (pick < 70) begin
        queue_sample(OP_NORM, 16'($urandom), 16'($urandom));
      end else if (pick < 90) begin
        queue_write($urandom_range(0, w - 1), $urandom_range(0, h - 1), rand_color());
      end else if (pick < 95 && (w < 256 || h < 256)) begin
        // Out-of-range write: must leave the image untouched.
        if (w < 256 && (h == 256 || $urandom_range(0, 1) == 0)) begin
          x = $urandom_range(w, 255);
          y = $urandom_range(0, 255);
        end else begin
          x = $urandom_range(0, 255);
          y = $urandom_range(h, 255);
        end
        queue_write(x, y, rand_color());
      end else begin
        queue_item(OP_NONE, 16'($urandom), 16'($urandom), rand_color());
      end
    end
  endtask

  // Driver: presents queued items and feeds each accepted one to the predictor.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_pixel(on_bus);
        items_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (src_gap > 0) begin
          src_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          on_bus = pending_items.pop_front();
          in_op <= on_bus.op;
          in_pos_x <= on_bus.pos_x;
          in_pos_y <= on_bus.pos_y;
          in_red <= on_bus.color.red;
          in_green <= on_bus.color.green;
          in_blue <= on_bus.color.blue;
          in_alpha <= on_bus.color.alpha;
          in_valid <= 1'b1;
          if (!calm && $urandom_range(0, 4) == 0) src_gap = $urandom_range(1, 4);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result and drives the result stall.
  always @(posedge clk) begin
    rgba_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{out_red, out_green, out_blue, out_alpha};
        if (expected_pixels.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result %h %h %h %h", got.red, got.green, got.blue,
                     got.alpha);
          mismatch_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.alpha !== want.alpha) begin
            if (mismatch_count < 10)
              $display("rgba mismatch: expected %h %h %h %h, got %h %h %h %h",
                       want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
            mismatch_count++;
          end
        end
      end
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (calm) begin
        out_stall <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 4) == 0) begin
        sink_gap = $urandom_range(1, 4) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus: directed corner cases at reset sizes, then random phases.
  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extreme colors at the four corners of both image ends.
    queue_write(0, 0, 32'h00000000);
    queue_write(1, 0, 32'hFFFFFFFF);
    queue_write(0, 1, 32'hFF00FF00);
    queue_write(1, 1, 32'h00FF00FF);
    queue_write(255, 255, 32'hFFFFFFFF);
    queue_write(254, 255, 32'h00000000);
    queue_write(255, 254, 32'h0F0F0F0F);
    queue_write(254, 254, 32'hF0F0F0F0);
    // Clamp below, exact texel, mid fractions, clamp above, largest fraction.
    queue_sample(OP_SAMPLE, 16'h0000, 16'h0000);
    queue_sample(OP_SAMPLE, 16'h0100, 16'h0100);
    queue_sample(OP_SAMPLE, 16'h0080, 16'h0040);
    queue_sample(OP_SAMPLE, 16'hFFFF, 16'hFFFF);
    queue_sample(OP_SAMPLE, 16'hFE80, 16'hFEC0);
    queue_sample(OP_SAMPLE, 16'h00FF, 16'h0000);
    // Normalised coordinates at both ends and the middle.
    queue_sample(OP_NORM, 16'h0000, 16'h0000);
    queue_sample(OP_NORM, 16'hFFFF, 16'hFFFF);
    queue_sample(OP_NORM, 16'h8000, 16'h8000);
    queue_item(OP_NONE, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF);
    queue_random(60);
    wait_drained();

    configure(9'd4, 9'd3, REG_SPARE_A);
    queue_random(150);
    wait_drained();

    // Zero and one both give a single-pixel image.
    configure(9'd0, 9'd1, REG_SPARE_B);
    queue_random(80);
    wait_drained();

    configure(9'd511, 9'd2, REG_SPARE_A);
    queue_random(80);
    wait_drained();

    // Long receiver hold-off while the sender keeps offering items.
    configure(9'd16, 9'd16, REG_SPARE_B);
    hold_req = 1'b1;
    queue_random(100);
    wait_drained();

    configure(9'd7, 9'd300, REG_SPARE_A);
    queue_random(60);
    wait_drained();

    // Final stretch without idling on either side.
    configure(9'd2, 9'd5, REG_SPARE_B);
    calm = 1'b1;
    queue_random(80);
    wait_drained();

    if (mismatch_count == 0) begin
      $display("bilinear_image_sampler: match");
    end else begin
      $display("bilinear_image_sampler: mismatch");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("bilinear_image_sampler: mismatch");
    $finish;
  end

endmodule
